### rtl/fcr_pkg.sv
`default_nettype none

package fcr_pkg;

  // Fixed field widths of the stream payload
  localparam int unsigned IDW       = 10;  // word identifier
  localparam int unsigned CNTW      = 32;  // miss counter
  localparam int unsigned CAPW      = 8;   // capacity register
  localparam int unsigned IN_TDW    = 16;
  localparam int unsigned OUT_TDW   = 48;
  localparam int unsigned OUT_TUW   = 2;

  localparam logic [CAPW-1:0] CAP_RESET = 8'd128;

  // Defaults for the top-level parameters
  localparam int unsigned DEF_WORD_SPACE = 1024;
  localparam int unsigned DEF_RING_DEPTH = 128;

  // Fraction bits of the reciprocal used for the word-space reduction
  localparam int unsigned RECIP_SHIFT = 20;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_REDUCE,
    ST_LOOKUP,
    ST_DECIDE,
    ST_APPEND,
    ST_DONE
  } fcr_state_t;

  typedef struct packed {
    logic clear;   // clear one presence entry
    logic accept;  // capture the incoming beat
    logic reduce;  // finish the word-space reduction
    logic lookup;  // read presence map and oldest ring slot
    logic decide;  // hit/miss, eviction
    logic append;  // mark present, write ring tail
    logic load;    // move result into the output register
  } fcr_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic hit;
    logic out_free;
  } fcr_sts_t;

endpackage

`default_nettype wire

### rtl/fifo_cache_replacement_core.sv
// Channel  Direction  tdata (low bit up)                          tuser (low bit up)
// in_      slave      word_id[9:0], zero pad to 16               -
// out_     master     evicted_word[9:0], miss_total[41:10],      is_miss[0], did_evict[1]
//                     zero pad to 48
// cfg_     write      cfg_wdata = cache_capacity[7:0]            -
//
// A hit passes through reduce, look up and decide to reach the output register, and a
// miss also through append; the next beat is taken once the result is loaded.
// Reset clears the presence map entry by entry with in_tready low;
// configuration writes are taken at any time.
// A stalled result holds in the output register; the next beat is still accepted
// and processed, then waits in the done step until the register frees.
`default_nettype none

module fifo_cache_replacement_core import fcr_pkg::*; #(
  parameter int unsigned WORD_SPACE = DEF_WORD_SPACE,
  parameter int unsigned RING_DEPTH = DEF_RING_DEPTH
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_tvalid,
  output logic                    in_tready,
  input  wire logic [IN_TDW-1:0]  in_tdata,   // word_id[9:0]
  output logic                    out_tvalid,
  input  wire logic               out_tready,
  output logic [OUT_TDW-1:0]      out_tdata,  // evicted_word[9:0], miss_total[41:10]
  output logic [OUT_TUW-1:0]      out_tuser,  // is_miss[0], did_evict[1]
  input  wire logic               cfg_we,
  input  wire logic [CAPW-1:0]    cfg_wdata
);

  fcr_cmd_t cmd;
  fcr_sts_t sts;

  // Sequence each reference: reduce, look up, decide, append on a miss, deliver
  fcr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Hold the presence map, the resident ring, counters and the output register
  fcr_datapath #(
    .WORD_SPACE (WORD_SPACE),
    .RING_DEPTH (RING_DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_word    (in_tdata[IDW-1:0]),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

`default_nettype wire

### rtl/fcr_ram.sv
`default_nettype none

module fcr_ram #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 2,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

### rtl/fcr_ctrl.sv
`default_nettype none

module fcr_ctrl import fcr_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_tvalid,
  output logic          in_tready,
  input  wire fcr_sts_t sts,
  output fcr_cmd_t      cmd
);

  fcr_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR:  if (sts.clr_last) state_nxt = ST_IDLE;
      ST_IDLE:   if (in_tvalid) state_nxt = ST_REDUCE;
      ST_REDUCE: state_nxt = ST_LOOKUP;
      ST_LOOKUP: state_nxt = ST_DECIDE;
      ST_DECIDE: state_nxt = sts.hit ? ST_DONE : ST_APPEND;
      ST_APPEND: state_nxt = ST_DONE;
      ST_DONE:   if (sts.out_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      ST_CLEAR:  cmd.clear = 1'b1;
      ST_IDLE: begin
        in_tready  = 1'b1;
        cmd.accept = in_tvalid;
      end
      ST_REDUCE: cmd.reduce = 1'b1;
      ST_LOOKUP: cmd.lookup = 1'b1;
      ST_DECIDE: cmd.decide = 1'b1;
      ST_APPEND: cmd.append = 1'b1;
      ST_DONE:   cmd.load   = sts.out_free;
      default:   cmd        = '0;
    endcase
  end

endmodule

`default_nettype wire

### rtl/fcr_datapath.sv
`default_nettype none

module fcr_datapath import fcr_pkg::*; #(
  parameter int unsigned WORD_SPACE = DEF_WORD_SPACE,
  parameter int unsigned RING_DEPTH = DEF_RING_DEPTH
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire fcr_cmd_t            cmd,
  output fcr_sts_t                 sts,
  input  wire logic [IDW-1:0]      in_word,
  input  wire logic                cfg_we,
  input  wire logic [CAPW-1:0]     cfg_wdata,
  output logic                     out_tvalid,
  input  wire logic                out_tready,
  output logic [OUT_TDW-1:0]       out_tdata,
  output logic [OUT_TUW-1:0]       out_tuser
);

  localparam int unsigned WAW   = $clog2(WORD_SPACE);
  localparam int unsigned RAW   = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int unsigned OCW   = $clog2(RING_DEPTH + 1);
  localparam int unsigned CMPW  = (OCW > CAPW) ? OCW : CAPW;
  localparam int unsigned SUMW  = OCW + 1;
  localparam int unsigned PRW   = IDW + RECIP_SHIFT;
  localparam int unsigned WSW   = $clog2(WORD_SPACE + 1);
  localparam int unsigned QWW   = IDW + WSW;
  localparam int unsigned RECIP = (1 << RECIP_SHIFT) / WORD_SPACE;

  // Control state
  logic [WAW-1:0]  clr_r, clr_nxt;
  logic [RAW-1:0]  oldest_r, oldest_nxt;
  logic [OCW-1:0]  occ_r, occ_nxt;
  logic [CNTW-1:0] miss_r, miss_nxt;
  logic [CAPW-1:0] cap_r;
  logic            out_valid_r;

  // Payload
  logic [IDW-1:0]  word_r;
  logic [IDW-1:0]  quot_r;
  logic [WAW-1:0]  idx_r, idx_nxt;
  logic            res_miss_r, res_evict_r;
  logic [IDW-1:0]  res_victim_r;
  logic [CNTW-1:0] res_total_r;
  logic            out_miss_r, out_evict_r;
  logic [IDW-1:0]  out_victim_r;
  logic [CNTW-1:0] out_total_r;

  logic [PRW-1:0]  recip_prod;
  logic [QWW-1:0]  quot_mul, rem_est, rem_fix;
  logic [CMPW-1:0] cap_z, eff_cap;
  logic            evict;
  logic [SUMW-1:0] tail_sum;
  logic [RAW-1:0]  tail;
  logic            pres_q;
  logic [WAW-1:0]  ring_q;

  logic            pm_we, pm_wdata;
  logic [WAW-1:0]  pm_waddr;

  // word mod WORD_SPACE: reciprocal estimate is exact or one low
  assign recip_prod = PRW'(in_word) * PRW'(RECIP);
  assign quot_mul   = QWW'(quot_r) * QWW'(WORD_SPACE);
  assign rem_est    = QWW'(word_r) - quot_mul;
  assign rem_fix    = (rem_est >= QWW'(WORD_SPACE)) ? rem_est - QWW'(WORD_SPACE) : rem_est;
  assign idx_nxt    = WAW'(rem_fix);

  always_comb begin
    cap_z = CMPW'(cap_r);
    priority if (cap_z == '0) begin
      eff_cap = CMPW'(1);
    end else if (cap_z > CMPW'(RING_DEPTH)) begin
      eff_cap = CMPW'(RING_DEPTH);
    end else begin
      eff_cap = cap_z;
    end
  end

  assign evict = CMPW'(occ_r) >= eff_cap;

  assign tail_sum = SUMW'(oldest_r) + SUMW'(occ_r);
  assign tail     = (tail_sum >= SUMW'(RING_DEPTH)) ? RAW'(tail_sum - SUMW'(RING_DEPTH))
                                                  : RAW'(tail_sum);

  always_comb begin
    pm_we    = cmd.clear | cmd.append | (cmd.decide & ~pres_q & evict);
    pm_wdata = cmd.append;
    priority if (cmd.clear) begin
      pm_waddr = clr_r;
    end else if (cmd.decide) begin
      pm_waddr = ring_q;
    end else begin
      pm_waddr = idx_r;
    end
  end

  fcr_ram #(.WIDTH(1), .DEPTH(WORD_SPACE)) u_presence (
    .clk     (clk),
    .wr_en   (pm_we),
    .wr_addr (pm_waddr),
    .wr_data (pm_wdata),
    .rd_en   (cmd.lookup),
    .rd_addr (idx_r),
    .rd_data (pres_q)
  );

  fcr_ram #(.WIDTH(WAW), .DEPTH(RING_DEPTH)) u_ring (
    .clk     (clk),
    .wr_en   (cmd.append),
    .wr_addr (tail),
    .wr_data (idx_r),
    .rd_en   (cmd.lookup),
    .rd_addr (oldest_r),
    .rd_data (ring_q)
  );

  always_comb begin
    clr_nxt    = cmd.clear ? clr_r + WAW'(1) : clr_r;
    oldest_nxt = oldest_r;
    occ_nxt    = occ_r;
    miss_nxt   = miss_r;
    if (cmd.decide && !pres_q) begin
      if (miss_r != '1) begin
        miss_nxt = miss_r + CNTW'(1);
      end
      if (evict) begin
        oldest_nxt = (oldest_r == RAW'(RING_DEPTH - 1)) ? '0 : oldest_r + RAW'(1);
        occ_nxt    = occ_r - OCW'(1);
      end
    end
    if (cmd.append) begin
      occ_nxt = occ_r + OCW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r       <= '0;
      oldest_r    <= '0;
      occ_r       <= '0;
      miss_r      <= '0;
      cap_r       <= CAP_RESET;
      out_valid_r <= 1'b0;
    end else begin
      clr_r    <= clr_nxt;
      oldest_r <= oldest_nxt;
      occ_r    <= occ_nxt;
      miss_r   <= miss_nxt;
      if (cfg_we) begin
        cap_r <= cfg_wdata;
      end
      priority if (cmd.load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      word_r <= in_word;
      quot_r <= recip_prod[PRW-1:RECIP_SHIFT];
    end
    if (cmd.reduce) begin
      idx_r <= idx_nxt;
    end
    if (cmd.decide) begin
      res_miss_r   <= ~pres_q;
      res_evict_r  <= ~pres_q & evict;
      res_victim_r <= (~pres_q & evict) ? IDW'(ring_q) : '0;
      res_total_r  <= miss_nxt;
    end
    if (cmd.load) begin
      out_miss_r   <= res_miss_r;
      out_evict_r  <= res_evict_r;
      out_victim_r <= res_victim_r;
      out_total_r  <= res_total_r;
    end
  end

  assign sts.clr_last = (clr_r == WAW'(WORD_SPACE - 1));
  assign sts.hit      = pres_q;
  assign sts.out_free = ~out_valid_r | out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tuser  = {out_evict_r, out_miss_r};
  assign out_tdata  = {{(OUT_TDW - IDW - CNTW){1'b0}}, out_total_r, out_victim_r};

endmodule

`default_nettype wire

### rtl/fcr_checker.sv
`default_nettype none

module fcr_sva import fcr_pkg::*; (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_tready,
  input wire logic               out_tvalid,
  input wire logic               out_tready,
  input wire logic [OUT_TDW-1:0] out_tdata,
  input wire logic [OUT_TUW-1:0] out_tuser
);

  // Stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result beat changed while stalled");

  // Eviction only on a miss
  a_evict_miss: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] |-> out_tuser[0])
    else $error("eviction reported on a hit");

  // No eviction means a zero victim
  a_victim_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[1] |-> out_tdata[IDW-1:0] == '0)
    else $error("victim word set without eviction");

  // A miss leaves a nonzero running count
  a_count_miss: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata[IDW+CNTW-1:IDW] != '0)
    else $error("miss reported with zero miss count");

  // Reset empties the output and starts the clearing pass
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && !in_tready)
    else $error("block not quiet after reset");

endmodule

bind fifo_cache_replacement_core fcr_sva u_fcr_sva (.*);

`default_nettype wire
